@@ sv/dep_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Types and codes shared by the storage cells and the top level.
// ----------------------------------------------------------------------------
package dep_pkg;

   localparam int ID_BITS   = 20;
   localparam int PRIO_BITS = 24;

   // Request modes
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_POP_MAX = 2'd1;
   localparam logic [1:0] MODE_POP_MIN = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_POPPED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_POP_MAX,
      OP_POP_MIN
   } op_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [ID_BITS-1:0]   client_id;
      logic [PRIO_BITS-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ID_BITS-1:0] popped_id;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      op_type    op;
      entry_type new_entry;
   } cmd_type;

endpackage

@@ sv/dep_cell.sv @@
// ----------------------------------------------------------------------------
// Queue storage cell
// Holds one entry of the sorted chain and shifts it to or from its
// neighbours as the broadcast command requires.
// ----------------------------------------------------------------------------
module dep_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  dep_pkg::cmd_type               cmd,
   input  dep_pkg::entry_type             left_entry,
   input  logic                           left_after,
   input  dep_pkg::entry_type             right_entry,
   output dep_pkg::entry_type             entry,
   output logic                           after,
   output logic [dep_pkg::ID_BITS-1:0]    top_id
);
   import dep_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign entry = entry_ff;

   // This cell lies at or beyond the insertion point of the new word.
   assign after = !(entry_ff.valid && (entry_ff.prio < cmd.new_entry.prio));

   // The highest occupied cell offers its id for a pop of the maximum.
   assign top_id = (entry_ff.valid && !right_entry.valid) ? entry_ff.id : '0;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (left_after) begin
               entry_in = left_entry;
            end else if (after) begin
               entry_in = cmd.new_entry;
            end
         end
         OP_POP_MAX: begin
            entry_in.valid = entry_ff.valid && right_entry.valid;
         end
         OP_POP_MIN: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id   <= entry_in.id;
      entry_ff.prio <= entry_in.prio;
   end

endmodule

@@ sv/double_ended_priority_queue.sv @@
// A result word is registered and appears on rsp_data in the cycle after its request is taken.
// Throughput: one request per cycle; the whole cell chain sorts, shifts or
// drops an entry in parallel, so busy stays low in normal operation.
// Reset: synchronous; a reset clears every cell and so empties the queue;
// busy is high through reset and in the cycle after it.
// The receiver cannot stall: rsp_strobe marks each result for one cycle only.
// ----------------------------------------------------------------------------
// Double-ended priority queue
// Sorted chain of cells, lowest priority in cell 0, serving insert, pop
// highest and pop lowest requests with one status word per request.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dep_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dep_pkg::rsp_type rsp_data
);
   import dep_pkg::*;

   entry_type                cells      [CAPACITY];
   logic                     cell_after [CAPACITY];
   logic [ID_BITS-1:0]       cell_top   [CAPACITY];
   logic [CAPACITY-1:0]      valid_vec;
   cmd_type                  cmd;
   logic                     accept;
   logic                     full;
   logic                     empty;
   logic [ID_BITS-1:0]       max_id;
   rsp_type                  rsp_in;
   rsp_type                  rsp_ff;
   logic                     rsp_strobe_ff;
   logic                     busy_ff;

   assign accept = start && !busy_ff;
   assign full   = cells[CAPACITY-1].valid;
   assign empty  = !cells[0].valid;

   always_comb begin
      cmd.op              = OP_NONE;
      cmd.new_entry.valid = 1'b1;
      cmd.new_entry.id    = req_data.client_id;
      cmd.new_entry.prio  = req_data.priority_req;
      rsp_in.status       = ST_EMPTY;
      rsp_in.popped_id    = '0;
      case (req_data.mode)
         MODE_INSERT: begin
            rsp_in.status = full ? ST_FULL : ST_INSERTED;
            if (accept && !full) begin
               cmd.op = OP_INSERT;
            end
         end
         MODE_POP_MAX: begin
            if (!empty) begin
               rsp_in.status    = ST_POPPED;
               rsp_in.popped_id = max_id;
               if (accept) begin
                  cmd.op = OP_POP_MAX;
               end
            end
         end
         MODE_POP_MIN: begin
            if (!empty) begin
               rsp_in.status    = ST_POPPED;
               rsp_in.popped_id = cells[0].id;
               if (accept) begin
                  cmd.op = OP_POP_MIN;
               end
            end
         end
         default: begin
            rsp_in.status = ST_EMPTY;
         end
      endcase
   end

   // At most one cell offers a non-zero id, so an OR gathers it.
   always_comb begin
      max_id = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         max_id = max_id | cell_top[i];
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         entry_type left_e;
         entry_type right_e;
         logic      left_a;

         if (g == 0) begin : g_first
            assign left_e = '0;
            assign left_a = 1'b0;
         end else begin : g_mid
            assign left_e = cells[g-1];
            assign left_a = cell_after[g-1];
         end

         if (g == CAPACITY - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_inner
            assign right_e = cells[g+1];
         end

         dep_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_after  (left_a),
            .right_entry (right_e),
            .entry       (cells[g]),
            .after       (cell_after[g]),
            .top_id      (cell_top[g])
         );

         assign valid_vec[g] = cells[g].valid;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         busy_ff       <= 1'b1;
      end else begin
         rsp_strobe_ff <= accept;
         busy_ff       <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Occupied cells always form a run starting at cell 0.
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1}) & valid_vec) == '0)
      else $error("occupied cells are not contiguous from cell 0");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted request produced no result word");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result word without an accepted request");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_INSERT) |=>
         (valid_vec == (($past(valid_vec) << 1) | {{(CAPACITY-1){1'b0}}, 1'b1})))
      else $error("insert did not add exactly one occupied cell");

   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ST_POPPED)) |-> (rsp_data.popped_id == '0))
      else $error("non-zero id on a result that popped nothing");

endmodule

@@ verif/tb_double_ended_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended priority queue testbench
// Drives insert, pop highest, pop lowest and unused mode words, mostly with
// random gaps, keeps a sorted copy of the stored entries to predict every
// status word, and compares each result word against that prediction.
// ----------------------------------------------------------------------------
module tb_double_ended_priority_queue;

   import dep_pkg::*;

   localparam int QCAP         = 64;
   localparam int ID_MAX       = (1 << ID_BITS) - 1;
   localparam int PRIO_MAX     = (1 << PRIO_BITS) - 1;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   // The fourth mode code has no meaning and must be ignored by the block.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [PRIO_BITS-1:0] prio;
      logic [ID_BITS-1:0]   id;
   } stored_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Entries ascending by priority, mirroring the cell chain.
   stored_entry_type sorted_entries[$];
   rsp_type          pending_status[$];
   int               error_count = 0;
   bit               idle_on = 1'b1;

   double_ended_priority_queue #(
      .CAPACITY(QCAP)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type predict_status(input req_type w);
      rsp_type          r;
      stored_entry_type e;
      int               pos;
      r.status    = ST_EMPTY;
      r.popped_id = '0;
      case (w.mode)
         MODE_INSERT: begin
            if (sorted_entries.size() >= QCAP) begin
               r.status = ST_FULL;
            end else begin
               // A new entry goes below any stored entries of equal priority.
               pos = 0;
               while (pos < sorted_entries.size() && sorted_entries[pos].prio < w.priority_req)
                  pos++;
               e.prio = w.priority_req;
               e.id   = w.client_id;
               sorted_entries.insert(pos, e);
               r.status = ST_INSERTED;
            end
         end
         MODE_POP_MAX: begin
            if (sorted_entries.size() != 0) begin
               e = sorted_entries.pop_back();
               r.status    = ST_POPPED;
               r.popped_id = e.id;
            end
         end
         MODE_POP_MIN: begin
            if (sorted_entries.size() != 0) begin
               e = sorted_entries.pop_front();
               r.status    = ST_POPPED;
               r.popped_id = e.id;
            end
         end
         default: begin
            r.status = ST_EMPTY;
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_word(input logic [1:0] mode, input int id, input int prio);
      req_type w;
      w.mode         = mode;
      w.client_id    = id[ID_BITS-1:0];
      w.priority_req = prio[PRIO_BITS-1:0];
      return w;
   endfunction

   // tie_range of zero spreads priorities over the whole field; otherwise they
   // cluster at both ends of the range so that equal keys are common.
   function automatic req_type random_word(input int insert_pct, input int tie_range);
      int   pick;
      int   id;
      int   prio;
      logic [1:0] mode;
      id   = $urandom_range(ID_MAX, 0);
      prio = $urandom_range(PRIO_MAX, 0);
      pick = $urandom_range(15, 0);
      if (pick == 0) id = 0;
      else if (pick == 1) id = ID_MAX;
      pick = $urandom_range(15, 0);
      if (tie_range > 0) begin
         prio = $urandom_range(tie_range, 0);
         if ($urandom_range(1, 0) == 1) prio = PRIO_MAX - prio;
      end else if (pick == 0) begin
         prio = 0;
      end else if (pick == 1) begin
         prio = PRIO_MAX;
      end
      pick = $urandom_range(99, 0);
      if (pick < insert_pct) mode = MODE_INSERT;
      else if (pick >= 97) mode = MODE_UNUSED;
      else if ($urandom_range(1, 0) == 1) mode = MODE_POP_MAX;
      else mode = MODE_POP_MIN;
      return make_word(mode, id, prio);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input req_type w);
      while (idle_on && $urandom_range(99, 0) < 24) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = w;
      do @(posedge clock); while (busy !== 1'b0);
      pending_status.push_back(predict_status(w));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_random(input int count, input int insert_pct, input int tie_range);
      repeat (count) send_word(random_word(insert_pct, tie_range));
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s: expected status %0d id %0h, got status %0d id %0h",
                  $realtime, what, want.status, want.popped_id, got.status, got.popped_id);
   endtask

   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_status.size() == 0) begin
            want = '0;
            note_mismatch("unexpected result word", want, rsp_data);
         end else begin
            want = pending_status.pop_front();
            if (rsp_data.status !== want.status || rsp_data.popped_id !== want.popped_id)
               note_mismatch("result word mismatch", want, rsp_data);
         end
      end
   end

   task automatic test_empty_queue;
      send_word(make_word(MODE_POP_MAX, ID_MAX, PRIO_MAX));
      send_word(make_word(MODE_POP_MIN, ID_MAX, 0));
      send_word(make_word(MODE_UNUSED, 0, PRIO_MAX));
   endtask

   task automatic test_extremes_and_ties;
      send_word(make_word(MODE_INSERT, 0, 0));
      send_word(make_word(MODE_INSERT, ID_MAX, PRIO_MAX));
      send_word(make_word(MODE_INSERT, 'h55555, 'h800000));
      send_word(make_word(MODE_INSERT, 'hA1, 'h100));
      send_word(make_word(MODE_INSERT, 'hA2, 'h100));
      send_word(make_word(MODE_INSERT, 'hA3, 'h100));
      send_word(make_word(MODE_UNUSED, 'hAAAAA, 'h555555));
      send_word(make_word(MODE_POP_MAX, 0, 0));
      send_word(make_word(MODE_POP_MIN, 0, 0));
      send_word(make_word(MODE_POP_MAX, 0, 0));
      // Highest pop takes the oldest of equal keys, lowest pop the newest.
      send_word(make_word(MODE_POP_MAX, 0, 0));
      send_word(make_word(MODE_POP_MIN, 0, 0));
      send_word(make_word(MODE_POP_MIN, 0, 0));
      send_word(make_word(MODE_POP_MIN, 0, 0));
      send_word(make_word(MODE_INSERT, 'h12345, PRIO_MAX));
      send_word(make_word(MODE_INSERT, 'h54321, PRIO_MAX));
      send_word(make_word(MODE_POP_MIN, ID_MAX, PRIO_MAX));
      send_word(make_word(MODE_POP_MAX, ID_MAX, PRIO_MAX));
   endtask

   task automatic test_random_mix;
      send_random(350, 55, 0);
   endtask

   // Runs the queue into the full state, then down past empty, twice.
   task automatic test_fill_and_drain;
      repeat (2) begin
         send_random(100, 85, 0);
         send_random(100, 12, 0);
      end
   endtask

   task automatic test_equal_priorities;
      send_random(200, 55, 3);
   endtask

   task automatic test_back_to_back;
      idle_on = 1'b0;
      send_random(100, 50, 0);
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_queue();
      test_extremes_and_ties();
      test_random_mix();
      test_fill_and_drain();
      test_equal_priorities();
      test_back_to_back();
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_status.size() == 0) begin
         $display("tb_double_ended_priority_queue: done, clean");
      end else begin
         $display("tb_double_ended_priority_queue: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_double_ended_priority_queue: done, errors");
      $finish;
   end

endmodule
